@@ rtl/igcd_pkg.sv @@
// Package for the integer gcd unit: microcode word types, step codes and
// the control program. Standalone, no dependencies.
`default_nettype none

package igcd_pkg;

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_ZERO   = 3'd1;
  localparam step_t STEP_COMMON = 3'd2;
  localparam step_t STEP_ODD_A  = 3'd3;
  localparam step_t STEP_REDUCE = 3'd4;
  localparam step_t STEP_EMIT   = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_ZFIX,
    OP_HALVE_BOTH,
    OP_HALVE_A,
    OP_REDUCE,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_INPUT,
    C_ANY_ZERO,
    C_BOTH_EVEN,
    C_A_EVEN,
    C_B_NONZERO,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jump_true;
    step_t jump_false;
  } ctrl_t;

  function automatic ctrl_t ucode(step_t step);
    ctrl_t w;
    case (step)
      STEP_IDLE:   w = '{OP_LOAD,       C_NO_INPUT,  STEP_IDLE,   STEP_ZERO};
      STEP_ZERO:   w = '{OP_ZFIX,       C_ANY_ZERO,  STEP_EMIT,   STEP_COMMON};
      STEP_COMMON: w = '{OP_HALVE_BOTH, C_BOTH_EVEN, STEP_COMMON, STEP_ODD_A};
      STEP_ODD_A:  w = '{OP_HALVE_A,    C_A_EVEN,    STEP_ODD_A,  STEP_REDUCE};
      STEP_REDUCE: w = '{OP_REDUCE,     C_B_NONZERO, STEP_REDUCE, STEP_EMIT};
      STEP_EMIT:   w = '{OP_EMIT,       C_OUT_BUSY,  STEP_EMIT,   STEP_IDLE};
      default:     w = '{OP_NOP,        C_ALWAYS,    STEP_IDLE,   STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/integer_gcd_unit.sv @@
// Integer gcd unit: binary (Stein) gcd run by a small microcode program.
// Depends on igcd_pkg for the control word types and the program table.
//
//   channel | dir | payload
//   s_*     | in  | tdata: first_value, second_value
//   m_*     | out | tdata: divisor
//
// One item at a time; the time an item holds the sequencer is shortest for a
// zero operand and otherwise set by the common halving, the halving of the first
// operand and the shift and subtract loop of the reduce step. The result sits
// in an output register, so the next item is taken while it waits. Reset (rst,
// synchronous) returns the step counter to idle and empties the output
// register. A stalled result holds the emit step.
`default_nettype none

module integer_gcd_unit #(
  parameter int VALUE_WIDTH = 16
) (
  input  wire                                       clk,
  input  wire                                       rst,
  input  wire                                       s_tvalid,
  output logic                                      s_tready,
  // first_value, second_value (lowest bits first)
  input  wire  [((2*VALUE_WIDTH+7)/8)*8-1:0]        s_tdata,
  output logic                                      m_tvalid,
  input  wire                                       m_tready,
  // divisor
  output logic [((VALUE_WIDTH+7)/8)*8-1:0]          m_tdata
);
  import igcd_pkg::*;

  localparam int KW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int OW = ((VALUE_WIDTH+7)/8)*8;

  step_t                   pc;
  step_t                   pc_next;
  ctrl_t                   cw;
  logic                    cond_hit;
  logic [VALUE_WIDTH-1:0]  a;
  logic [VALUE_WIDTH-1:0]  b;
  logic [KW-1:0]           k;
  logic [VALUE_WIDTH-1:0]  result;
  logic                    out_valid;
  logic                    out_busy;
  logic                    in_fire;
  logic                    a_gt_b;
  logic [VALUE_WIDTH-1:0]  diff;

  assign cw       = ucode(pc);
  assign s_tready = (pc == STEP_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_busy = out_valid && !m_tready;
  assign a_gt_b   = a > b;
  assign diff     = a_gt_b ? (a - b) : (b - a);
  assign m_tvalid = out_valid;

  always_comb begin
    case (cw.cond)
      C_ALWAYS:    cond_hit = 1'b1;
      C_NO_INPUT:  cond_hit = !in_fire;
      C_ANY_ZERO:  cond_hit = (a == '0) || (b == '0);
      C_BOTH_EVEN: cond_hit = !a[0] && !b[0];
      C_A_EVEN:    cond_hit = !a[0];
      C_B_NONZERO: cond_hit = (b != '0);
      C_OUT_BUSY:  cond_hit = out_busy;
      default:     cond_hit = 1'b1;
    endcase
    pc_next = cond_hit ? cw.jump_true : cw.jump_false;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    case (cw.op)
      OP_LOAD: begin
        if (in_fire) begin
          a <= s_tdata[VALUE_WIDTH-1:0];
          b <= s_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
          k <= '0;
        end
      end
      OP_ZFIX: begin
        if (a == '0) begin
          a <= b;
        end
      end
      OP_HALVE_BOTH: begin
        if (!a[0] && !b[0]) begin
          a <= a >> 1;
          b <= b >> 1;
          k <= k + 1'b1;
        end
      end
      OP_HALVE_A: begin
        if (!a[0]) begin
          a <= a >> 1;
        end
      end
      OP_REDUCE: begin
        if (!b[0]) begin
          b <= b >> 1;
        end else begin
          a <= a_gt_b ? b : a;
          b <= diff;
        end
      end
      default: begin
      end
    endcase
  end

  assign result = a << k;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.op == OP_EMIT && !out_busy) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == OP_EMIT && !out_busy) begin
      m_tdata <= OW'(result);
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_integer_gcd_unit.sv @@
// Testbench for integer_gcd_unit: stream driver and monitor, with a Euclid
// predictor that checks every divisor beat in order.
// Needs only the integer_gcd_unit RTL and its package.
`default_nettype none

module tb_integer_gcd_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW         = 16;
  localparam int S_BITS     = ((2 * VW + 7) / 8) * 8;
  localparam int M_BITS     = ((VW + 7) / 8) * 8;
  localparam int RAND_ITEMS = 800;
  localparam int STALL_MAX  = 4000;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_WAIT = 2 * VW + 8;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [S_BITS-1:0] s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [M_BITS-1:0] m_tdata;

  logic [S_BITS-1:0] pending_pairs[$];
  logic [VW-1:0]     gcd_expected[$];

  int   errors        = 0;
  int   results_seen  = 0;
  int   pairs_taken   = 0;
  int   zero_pairs    = 0;
  int   coprime_pairs = 0;
  int   stall_cycles  = 0;
  logic hold_off      = 1'b0;
  logic steady;

  integer_gcd_unit #(.VALUE_WIDTH(VW)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // first_value, second_value
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // divisor
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [VW-1:0] euclid_gcd(logic [VW-1:0] x, logic [VW-1:0] y);
    logic [VW-1:0] r;
    while (y != '0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  task automatic queue_pair(int first, int second);
    logic [S_BITS-1:0] beat;
    beat = '0;
    beat[VW-1:0]    = first[VW-1:0];
    beat[2*VW-1:VW] = second[VW-1:0];
    pending_pairs.push_back(beat);
  endtask

  // no idling on either side for a stretch in the second random phase
  assign steady = (results_seen >= 1000) && (results_seen < 1400);

  // sender
  always @(posedge clk) begin
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    logic [VW-1:0] g;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        a = s_tdata[VW-1:0];
        b = s_tdata[2*VW-1:VW];
        g = euclid_gcd(a, b);
        gcd_expected.push_back(g);
        pairs_taken <= pairs_taken + 1;
        if (a == '0 || b == '0) zero_pairs <= zero_pairs + 1;
        if (g == 1) coprime_pairs <= coprime_pairs + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_pairs.size() != 0 && (steady || $urandom_range(99) >= 6)) begin
          s_tdata  <= pending_pairs.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    logic [VW-1:0] want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (gcd_expected.size() == 0) begin
          $display("%0t: divisor beat with nothing expected, actual %0d", $time,
                   m_tdata[VW-1:0]);
          errors <= errors + 1;
        end else begin
          want = gcd_expected.pop_front();
          if (m_tdata[VW-1:0] !== want) begin
            $display("%0t: divisor mismatch, expected %0d, actual %0d", $time, want,
                     m_tdata[VW-1:0]);
            errors <= errors + 1;
          end
        end
      end
      m_tready <= !hold_off && (steady || $urandom_range(99) >= 6);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_MAX);
    $display("%0t: no beat accepted for %0d cycles", $time, STALL_MAX);
    $display("== FAIL ==");
    $finish;
  end

  // hold off the receiver so the block backs up onto its input
  initial begin
    while (results_seen < 150) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    int sel;
    int g;
    int s;
    int a;
    int b;
    // extremes, zero operands, powers of two, shared and coprime factors
    queue_pair(1, 1);
    queue_pair(65535, 65535);
    queue_pair(65535, 1);
    queue_pair(1, 65535);
    queue_pair(0, 5);
    queue_pair(7, 0);
    queue_pair(0, 0);
    queue_pair(0, 65535);
    queue_pair(65535, 0);
    queue_pair(32768, 16384);
    queue_pair(32768, 1);
    queue_pair(65534, 32767);
    queue_pair(48, 18);
    queue_pair(17, 13);
    queue_pair(2, 65534);
    queue_pair(12345, 54321);
    queue_pair(40960, 61440);
    queue_pair(65535, 21845);
    queue_pair(1024, 4096);
    queue_pair(43690, 21845);
    queue_pair(32768, 32768);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 2; phase++) begin
      for (int i = 0; i < RAND_ITEMS; i++) begin
        sel = $urandom_range(15);
        a = $urandom_range(1, 65535);
        b = $urandom_range(1, 65535);
        if (sel >= 6 && sel <= 9) begin
          g = $urandom_range(2, 255);
          a = g * $urandom_range(1, 65535 / g);
          b = g * $urandom_range(1, 65535 / g);
        end else if (sel == 10 || sel == 11) begin
          s = $urandom_range(0, 15);
          a = $urandom_range(1, 65535 >> s) << s;
          s = $urandom_range(0, 15);
          b = $urandom_range(1, 65535 >> s) << s;
        end else if (sel == 12) begin
          b = a;
        end else if (sel == 13) begin
          a = b * $urandom_range(1, 65535 / b);
        end else if (sel == 14) begin
          a = $urandom_range(1, 16);
          b = $urandom_range(1, 16);
        end else if (sel == 15 && $urandom_range(3) == 0) begin
          if ($urandom_range(1)) a = 0;
          else b = 0;
        end
        queue_pair(a, b);
      end
      // pause the sender until every divisor is back
      while (pending_pairs.size() != 0 || s_tvalid || gcd_expected.size() != 0)
        @(posedge clk);
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("gcd run: %0d operand pairs, %0d divisors checked, %0d coprime, %0d with zero",
             pairs_taken, results_seen, coprime_pairs, zero_pairs);
    $display("receiver held off %0d cycles once, sender drained between two random phases",
             HOLD_LEN);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/igcd_pkg.sv
rtl/integer_gcd_unit.sv
tb/tb_integer_gcd_unit.sv
